[rtl/sobel_pkg.sv]
// ----------------------------------------------------------------------------
// sobel_pkg
// Shared types, register indexes and reset values for the 3x3 Sobel edge
// detector with threshold.
// ----------------------------------------------------------------------------
package sobel_pkg;

    typedef logic [7:0]         t_pix;
    typedef logic signed [10:0] t_grad;
    typedef logic [11:0]        t_row;
    typedef logic [9:0]         t_out_col;
    typedef logic [10:0]        t_thresh;
    typedef logic [10:0]        t_fwidth;
    typedef logic [12:0]        t_fheight;
    typedef logic [1:0]         t_cfg_idx;

    // configuration register indexes
    localparam t_cfg_idx CFG_EDGE_THRESHOLD = 2'd0;
    localparam t_cfg_idx CFG_FRAME_WIDTH    = 2'd1;
    localparam t_cfg_idx CFG_FRAME_HEIGHT   = 2'd2;

    localparam int CFG_DATA_W = 13;

    localparam t_thresh  RST_EDGE_THRESHOLD = 11'd128;
    localparam t_fwidth  RST_FRAME_WIDTH    = 11'd640;
    localparam t_fheight RST_FRAME_HEIGHT   = 13'd480;

    localparam t_fheight MIN_HEIGHT = 13'd3;
    localparam t_fheight MAX_HEIGHT = 13'd4096;

endpackage

[rtl/sobel_edge_threshold.sv]
// ----------------------------------------------------------------------------
// sobel_edge_threshold
// Streaming 3x3 Sobel edge detector: line buffers in one dual-port memory,
// a 3x3 window and a thresholded |gx|+|gy| decision per interior pixel.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels of the first color channel enter in raster order on the input
//   channel (i_valid/o_ready, one transaction per pixel). For every pixel at
//   row r >= 2 and column c >= 2 one result leaves on the output channel
//   (o_valid/i_ready) deciding interior pixel (r-1, c-1); border pixels give
//   no result. Columns wrap at each row end, rows at the end of each frame.
//   Throughput is one pixel per clock while the receiver does not stall: both
//   line buffers share one memory word that is read at accept and written
//   back one stage later, so consecutive pixels touch different columns.
//   An accepted pixel passes the stages memory read, window shift,
//   gradient sums, and magnitude and compare before reaching o_valid.
//   When the receiver stalls, the pipeline fills its free stages and then
//   drops o_ready; nothing is lost. The output register holds a waiting
//   result, so new pixels keep flowing until all four stages are full.
//   Reset clears counters, window, pipeline valids and restores the
//   register defaults; line buffer contents stay undefined until written.
//   Configuration writes (i_cfg_we) take effect at once and are meant for
//   idle periods only.
// ----------------------------------------------------------------------------
module sobel_edge_threshold #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  sobel_pkg::t_cfg_idx                i_cfg_idx,
    input  logic [sobel_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  sobel_pkg::t_pix                    i_pixel_value,
    output logic                               o_valid,
    input  logic                               i_ready,
    output sobel_pkg::t_row                    o_out_row,
    output sobel_pkg::t_out_col                o_out_col,
    output logic                               o_is_edge
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int LW = 14;
    localparam logic [LW-1:0] MAX_W = LW'(MAX_WIDTH);

    // configuration
    sobel_pkg::t_thresh  r_thresh;
    sobel_pkg::t_fwidth  r_fwidth;
    sobel_pkg::t_fheight r_fheight;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh  <= sobel_pkg::RST_EDGE_THRESHOLD;
            r_fwidth  <= sobel_pkg::RST_FRAME_WIDTH;
            r_fheight <= sobel_pkg::RST_FRAME_HEIGHT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sobel_pkg::CFG_EDGE_THRESHOLD: r_thresh  <= i_cfg_data[10:0];
                sobel_pkg::CFG_FRAME_WIDTH:    r_fwidth  <= i_cfg_data[10:0];
                sobel_pkg::CFG_FRAME_HEIGHT:   r_fheight <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // effective frame size
    logic [LW-1:0]       w_eff;
    logic [LW-1:0]       w_last;
    sobel_pkg::t_fheight h_eff;
    sobel_pkg::t_fheight h_last;

    always_comb begin
        if (r_fwidth < 11'd3) begin
            w_eff = LW'(3);
        end else if (LW'(r_fwidth) > MAX_W) begin
            w_eff = MAX_W;
        end else begin
            w_eff = LW'(r_fwidth);
        end
        w_last = w_eff - LW'(1);

        if (r_fheight < sobel_pkg::MIN_HEIGHT) begin
            h_eff = sobel_pkg::MIN_HEIGHT;
        end else if (r_fheight > sobel_pkg::MAX_HEIGHT) begin
            h_eff = sobel_pkg::MAX_HEIGHT;
        end else begin
            h_eff = r_fheight;
        end
        h_last = h_eff - 13'd1;
    end

    // pipeline handshake
    logic r_s1_v, r_s2_v, r_s3_v, r_o_v;
    logic out_rdy, s3_rdy, s2_rdy, s1_rdy;
    logic s3_go, s2_go, s1_go, in_acc;

    assign out_rdy = !r_o_v || i_ready;
    assign s3_go   = r_s3_v && out_rdy;
    assign s3_rdy  = !r_s3_v || out_rdy;
    assign s2_go   = r_s2_v && s3_rdy;
    assign s2_rdy  = !r_s2_v || s3_rdy;
    assign s1_go   = r_s1_v && s2_rdy;
    assign s1_rdy  = !r_s1_v || s2_rdy;
    assign in_acc  = i_valid && s1_rdy;
    assign o_ready = s1_rdy;

    // position counters
    logic [CW-1:0]   r_col, n_col;
    sobel_pkg::t_row r_row, n_row;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (in_acc) begin
            if (LW'(r_col) >= w_last) begin
                n_col = '0;
                if (13'(r_row) >= h_last) begin
                    n_row = '0;
                end else begin
                    n_row = r_row + 12'd1;
                end
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // line buffers: {upper, middle} per column, read at accept, written at s1
    logic [15:0]     mem_lines [MAX_WIDTH];
    logic [15:0]     r_line_rd;
    sobel_pkg::t_pix r_s1_px;
    logic [CW-1:0]   r_s1_col;
    sobel_pkg::t_row r_s1_row;
    logic            r_s1_prod;

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_line_rd <= mem_lines[r_col];
        end
        if (s1_go) begin
            mem_lines[r_s1_col] <= {r_line_rd[7:0], r_s1_px};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (in_acc) begin
            r_s1_v <= 1'b1;
        end else if (s1_go) begin
            r_s1_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_px   <= i_pixel_value;
            r_s1_col  <= r_col;
            r_s1_row  <= r_row;
            r_s1_prod <= (r_row >= 12'd2) && (LW'(r_col) >= LW'(2));
        end
    end

    // window shift, newest column on the right, newest row at the bottom
    sobel_pkg::t_pix     r_win [9];
    sobel_pkg::t_row     r_s2_row;
    sobel_pkg::t_out_col r_s2_col;
    logic [31:0]         s1_col_m1;

    assign s1_col_m1 = 32'(r_s1_col) - 32'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 9; i++) begin
                r_win[i] <= '0;
            end
            r_s2_v <= 1'b0;
        end else begin
            if (s1_go) begin
                for (int k = 0; k < 3; k++) begin
                    r_win[k*3]   <= r_win[k*3+1];
                    r_win[k*3+1] <= r_win[k*3+2];
                end
                r_win[2] <= r_line_rd[15:8];
                r_win[5] <= r_line_rd[7:0];
                r_win[8] <= r_s1_px;
                r_s2_v   <= r_s1_prod;
            end else if (s2_go) begin
                r_s2_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_s2_row <= r_s1_row - 12'd1;
            r_s2_col <= s1_col_m1[9:0];
        end
    end

    // gradient sums
    sobel_pkg::t_grad q [9];
    sobel_pkg::t_grad gx, gy;
    sobel_pkg::t_grad r_s3_gx, r_s3_gy;
    sobel_pkg::t_row     r_s3_row;
    sobel_pkg::t_out_col r_s3_col;

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            q[i] = signed'({3'b000, r_win[i]});
        end
        gx = (q[2] - q[0]) + ((q[5] - q[3]) <<< 1) + (q[8] - q[6]);
        gy = (q[6] - q[0]) + ((q[7] - q[1]) <<< 1) + (q[8] - q[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
        end else if (s2_go) begin
            r_s3_v <= 1'b1;
        end else if (s3_go) begin
            r_s3_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_go) begin
            r_s3_gx  <= gx;
            r_s3_gy  <= gy;
            r_s3_row <= r_s2_row;
            r_s3_col <= r_s2_col;
        end
    end

    // magnitude and threshold
    logic [10:0] abs_gx, abs_gy;
    logic [11:0] mag;

    always_comb begin
        abs_gx = r_s3_gx[10] ? 11'(-r_s3_gx) : 11'(r_s3_gx);
        abs_gy = r_s3_gy[10] ? 11'(-r_s3_gy) : 11'(r_s3_gy);
        mag    = {1'b0, abs_gx} + {1'b0, abs_gy};
    end

    sobel_pkg::t_row     r_o_row;
    sobel_pkg::t_out_col r_o_col;
    logic                r_o_edge;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (s3_go) begin
            r_o_v <= 1'b1;
        end else if (i_ready) begin
            r_o_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_go) begin
            r_o_row  <= r_s3_row;
            r_o_col  <= r_s3_col;
            r_o_edge <= mag > {1'b0, r_thresh};
        end
    end

    assign o_valid   = r_o_v;
    assign o_out_row = r_o_row;
    assign o_out_col = r_o_col;
    assign o_is_edge = r_o_edge;

endmodule
